// File: hw/rtl/xed_pkg.sv
// Shared types, constants and entity tables for the XML entity decoder.
package xed_pkg;

	localparam int unsigned ST_W         = 5;
	localparam int unsigned MATCH_STATES = 21;
	localparam int unsigned POS_W        = 3;

	localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
	localparam logic [ST_W-1:0] ST_AMP  = 5'd1;

	localparam logic [7:0] CH_AMP = 8'h26;

	// Work handed from the front to the back: an optional flush of a partial
	// entity (ampersand plus held bytes), then an optional single data byte.
	typedef struct packed {
		logic [ST_W-1:0] flush_st;
		logic            has_data;
		logic [7:0]      data;
		logic            last;
	} cmd_t;

	typedef struct packed {
		logic            found;
		logic [ST_W-1:0] to;
		logic [7:0]      dec;
	} edge_t;

	// One transition of the entity matcher; to == ST_IDLE means complete.
	function automatic edge_t match_step(input logic [ST_W-1:0] st, input logic [7:0] b);
		edge_t e;
		e = '{found: 1'b1, to: ST_IDLE, dec: 8'h00};
		case ({st, b})
			{5'd1,  8'h23}: e.to = 5'd2;
			{5'd2,  8'h31}: e.to = 5'd3;
			{5'd3,  8'h30}: e.to = 5'd4;
			{5'd4,  8'h3B}: e.dec = 8'h0A;
			{5'd3,  8'h33}: e.to = 5'd5;
			{5'd5,  8'h3B}: e.dec = 8'h0D;
			{5'd2,  8'h39}: e.to = 5'd6;
			{5'd6,  8'h3B}: e.dec = 8'h09;
			{5'd1,  8'h61}: e.to = 5'd7;
			{5'd7,  8'h6D}: e.to = 5'd8;
			{5'd8,  8'h70}: e.to = 5'd9;
			{5'd9,  8'h3B}: e.dec = 8'h26;
			{5'd7,  8'h70}: e.to = 5'd10;
			{5'd10, 8'h6F}: e.to = 5'd11;
			{5'd11, 8'h73}: e.to = 5'd12;
			{5'd12, 8'h3B}: e.dec = 8'h27;
			{5'd1,  8'h6C}: e.to = 5'd13;
			{5'd13, 8'h74}: e.to = 5'd14;
			{5'd14, 8'h3B}: e.dec = 8'h3C;
			{5'd1,  8'h67}: e.to = 5'd15;
			{5'd15, 8'h74}: e.to = 5'd16;
			{5'd16, 8'h3B}: e.dec = 8'h3E;
			{5'd1,  8'h71}: e.to = 5'd17;
			{5'd17, 8'h75}: e.to = 5'd18;
			{5'd18, 8'h6F}: e.to = 5'd19;
			{5'd19, 8'h74}: e.to = 5'd20;
			{5'd20, 8'h3B}: e.dec = 8'h22;
			default: e.found = 1'b0;
		endcase
		return e;
	endfunction

	// Number of bytes held after the ampersand in a match state.
	function automatic logic [POS_W-1:0] held_len(input logic [ST_W-1:0] st);
		logic [POS_W-1:0] n;
		case (st)
			5'd2, 5'd7, 5'd13, 5'd15, 5'd17:        n = 3'd1;
			5'd3, 5'd6, 5'd8, 5'd10, 5'd14, 5'd16, 5'd18: n = 3'd2;
			5'd4, 5'd5, 5'd9, 5'd11, 5'd19:         n = 3'd3;
			5'd12, 5'd20:                           n = 3'd4;
			default:                                n = 3'd0;
		endcase
		return n;
	endfunction

	// Held byte number idx of a match state.
	function automatic logic [7:0] held_char(input logic [ST_W-1:0] st, input logic [1:0] idx);
		logic [7:0] c;
		c = 8'h00;
		case (st)
			5'd2, 5'd3, 5'd4, 5'd5, 5'd6: begin
				case (idx)
					2'd0:    c = 8'h23;
					2'd1:    c = (st == 5'd6) ? 8'h39 : 8'h31;
					default: c = (st == 5'd5) ? 8'h33 : 8'h30;
				endcase
			end
			5'd7, 5'd8, 5'd9: begin
				case (idx)
					2'd0:    c = 8'h61;
					2'd1:    c = 8'h6D;
					default: c = 8'h70;
				endcase
			end
			5'd10, 5'd11, 5'd12: begin
				case (idx)
					2'd0:    c = 8'h61;
					2'd1:    c = 8'h70;
					2'd2:    c = 8'h6F;
					default: c = 8'h73;
				endcase
			end
			5'd13, 5'd14: c = (idx == 2'd0) ? 8'h6C : 8'h74;
			5'd15, 5'd16: c = (idx == 2'd0) ? 8'h67 : 8'h74;
			5'd17, 5'd18, 5'd19, 5'd20: begin
				case (idx)
					2'd0:    c = 8'h71;
					2'd1:    c = 8'h75;
					2'd2:    c = 8'h6F;
					default: c = 8'h74;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/xed_if.sv
// Valid/ready channel interfaces for encoded input words and decoded output words.
interface xed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       stream_end;

	modport source (output valid, output out_byte, output run_end, output stream_end,
		input ready);
	modport sink   (input valid, input out_byte, input run_end, input stream_end,
		output ready);
endinterface

// File: hw/rtl/xed_front.sv
// Front end: accepts input words, runs the entity matcher, issues commands.
module xed_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_data,
	input  logic          in_last,
	output logic          in_ready,
	input  logic          q_full,
	output logic          push,
	output xed_pkg::cmd_t cmd
);
	import xed_pkg::*;

	logic [ST_W-1:0] st_q;
	logic [ST_W-1:0] st;
	logic [ST_W-1:0] nst;
	logic [ST_W-1:0] nst_fin;
	edge_t           e;
	logic            accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		st = (st_q >= ST_W'(MATCH_STATES)) ? ST_IDLE : st_q;
		e  = match_step(st, in_data);
		cmd = '{flush_st: ST_IDLE, has_data: 1'b0, data: in_data, last: in_last};
		nst = ST_IDLE;
		if (st != ST_IDLE) begin
			if (e.found) begin
				nst = e.to;
				if (e.to == ST_IDLE) begin
					cmd.has_data = 1'b1;
					cmd.data     = e.dec;
				end
			end else begin
				cmd.flush_st = st;
				if (in_data == CH_AMP) begin
					nst = ST_AMP;
				end else begin
					cmd.has_data = 1'b1;
				end
			end
		end else if (in_data == CH_AMP) begin
			nst = ST_AMP;
		end else begin
			cmd.has_data = 1'b1;
		end
		// end of region: flush whatever partial entity remains
		nst_fin = nst;
		if (in_last && nst != ST_IDLE) begin
			nst_fin = ST_IDLE;
			if (cmd.flush_st == ST_IDLE) begin
				cmd.flush_st = nst;
			end else begin
				cmd.has_data = 1'b1;
				cmd.data     = CH_AMP;
			end
		end
	end

	assign push = accept && (cmd.has_data || cmd.flush_st != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else if (accept) begin
			st_q <= nst_fin;
		end
	end
endmodule

// File: hw/rtl/xed_queue.sv
// Short command queue between front and back.
module xed_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xed_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output xed_pkg::cmd_t rd_cmd,
	output logic          not_empty,
	output logic          full
);
	import xed_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == CNT_W'(DEPTH);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// File: hw/rtl/xed_back.sv
// Back end: expands each command into output words through an output register.
module xed_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  xed_pkg::cmd_t cmd,
	output logic          pop,
	output logic          out_valid,
	output logic [7:0]    out_data,
	output logic          out_run_end,
	output logic          out_stream_end,
	input  logic          out_ready
);
	import xed_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] hl;
	logic [POS_W-1:0] cnt;
	logic [POS_W-1:0] pos_m1;
	logic             flushing;
	logic             at_end;
	logic             load;
	logic [7:0]       nxt;
	logic             ov_q;
	logic [7:0]       data_q;
	logic             run_end_q;
	logic             stream_end_q;

	always_comb begin
		flushing = cmd.flush_st != ST_IDLE;
		hl       = held_len(cmd.flush_st);
		cnt      = (flushing ? hl + 3'd1 : 3'd0) + POS_W'(cmd.has_data);
		pos_m1   = pos_q - 3'd1;
		at_end   = pos_q == cnt - 3'd1;
		if (flushing && pos_q == 3'd0) begin
			nxt = CH_AMP;
		end else if (flushing && pos_q <= hl) begin
			nxt = held_char(cmd.flush_st, pos_m1[1:0]);
		end else begin
			nxt = cmd.data;
		end
	end

	assign load = cmd_valid && (!ov_q || out_ready);
	assign pop  = load && at_end;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q       <= nxt;
			run_end_q    <= at_end;
			stream_end_q <= at_end && cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			pos_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				pos_q <= at_end ? '0 : pos_q + 3'd1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid      = ov_q;
	assign out_data       = data_q;
	assign out_run_end    = run_end_q;
	assign out_stream_end = stream_end_q;
endmodule

// File: hw/rtl/xml_entity_decoder.sv
// Top level of the XML character entity decoder.
//
//   channel   | dir | words                      | payload
//   ----------+-----+----------------------------+---------------------------------
//   text_in   | in  | one encoded byte per word  | in_byte[7:0], in_last
//   text_out  | out | one decoded byte per word  | out_byte[7:0], run_end, stream_end
//
// Cycles: one input word per cycle while the queue has room and each
// word yields at most one output word; a word that flushes a partial
// entity yields up to six output words, and the back end drains them one
// per cycle from its output register while the output is taken. An accepted
// input word goes through the command queue into the output register.
// Reset: arst_n clears the match state, the queue and the output register.
// Stalls: the command queue (QDEPTH entries) parts front and back, so input
// stalls only when the queue fills; a held output word blocks only the back.
module xml_entity_decoder #(
	parameter int unsigned QDEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	xed_in_if.sink    text_in,
	xed_out_if.source text_out
);
	import xed_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;

	// Classify each input word and track the partial entity.
	xed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_data  (text_in.in_byte),
		.in_last  (text_in.in_last),
		.in_ready (text_in.ready),
		.q_full   (q_full),
		.push     (push),
		.cmd      (front_cmd)
	);

	// Hold pending commands so front and back stall independently.
	xed_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (front_cmd),
		.pop       (pop),
		.rd_cmd    (head_cmd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// Expand commands into output words, one per cycle unless the output stalls.
	xed_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (q_not_empty),
		.cmd            (head_cmd),
		.pop            (pop),
		.out_valid      (text_out.valid),
		.out_data       (text_out.out_byte),
		.out_run_end    (text_out.run_end),
		.out_stream_end (text_out.stream_end),
		.out_ready      (text_out.ready)
	);
endmodule
